// ===== hdl/bwss_pkg.sv =====
// ---------------------------------------------------------------------------
// bwss_pkg
// shared types and constants for the bounded wide substring search
// ---------------------------------------------------------------------------
package bwss_pkg;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_WRITE_PATTERN = 2'd0,
        OP_TEXT          = 2'd1,
        OP_RESTART       = 2'd2,
        OP_NOP           = 2'd3
    } t_op;

    // search status codes
    typedef enum logic [2:0] {
        ST_SEARCHING      = 3'd0,
        ST_FOUND          = 3'd1,
        ST_NOT_FOUND      = 3'd2,
        ST_TEXT_LIM_ZERO  = 3'd3,
        ST_TEXT_LIM_BIG   = 3'd4,
        ST_PAT_LIM_ZERO   = 3'd5,
        ST_PAT_LIM_BIG    = 3'd6,
        ST_PAT_OVER_STORE = 3'd7
    } t_status;

    // configuration register indexes
    localparam logic [3:0] CFG_TEXT_LIMIT    = 4'd0;
    localparam logic [3:0] CFG_PATTERN_LIMIT = 4'd1;

    // configuration reset values
    localparam logic [15:0] TEXT_LIMIT_RST    = 16'd1024;
    localparam logic [15:0] PATTERN_LIMIT_RST = 16'd32;

    typedef struct packed {
        t_op         op;
        logic [4:0]  pattern_index;
        logic [31:0] char_value;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] match_position;
    } t_result;

endpackage

// ===== hdl/bwss_store.sv =====
// ---------------------------------------------------------------------------
// bwss_store
// pattern character store with first-nul detect and parallel comparators
// ---------------------------------------------------------------------------
module bwss_store #(
    parameter int PATTERN_DEPTH = 32,
    parameter int CHAR_WIDTH    = 32,
    parameter int PW            = $clog2(PATTERN_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [4:0]               i_wr_index,
    input  logic [CHAR_WIDTH-1:0]    i_char,
    output logic [PW-1:0]            o_nul_index,
    output logic [PATTERN_DEPTH-1:0] o_hits
);

    logic [CHAR_WIDTH-1:0] r_store [PATTERN_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_wr_en) begin
            // index at or beyond the depth matches no entry and is dropped
            for (int i = 0; i < PATTERN_DEPTH; i++) begin
                if (7'(i_wr_index) == 7'(i)) begin
                    r_store[i] <= i_char;
                end
            end
        end
    end

    // first nul entry, depth when the store is full
    always_comb begin
        o_nul_index = PW'(PATTERN_DEPTH);
        for (int i = PATTERN_DEPTH - 1; i >= 0; i--) begin
            if (r_store[i] == '0) begin
                o_nul_index = PW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_DEPTH; i++) begin
            o_hits[i] = (r_store[i] == i_char);
        end
    end

endmodule

// ===== hdl/bwss_search.sv =====
// ---------------------------------------------------------------------------
// bwss_search
// search state and shift-and update for one transaction
// ---------------------------------------------------------------------------
module bwss_search #(
    parameter int PATTERN_DEPTH = 32,
    parameter int MAX_LENGTH    = 1024,
    parameter int CHAR_WIDTH    = 32,
    parameter int PW            = $clog2(PATTERN_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  bwss_pkg::t_op            i_op,
    input  logic [CHAR_WIDTH-1:0]    i_char,
    input  logic [PW-1:0]            i_nul_index,
    input  logic [PATTERN_DEPTH-1:0] i_hits,
    input  logic [15:0]              i_text_limit,
    input  logic [15:0]              i_pattern_limit,
    output bwss_pkg::t_result        o_result
);
    import bwss_pkg::*;

    localparam logic [15:0] MaxLen = 16'(MAX_LENGTH);
    localparam logic [15:0] Depth  = 16'(PATTERN_DEPTH);

    logic [PATTERN_DEPTH-1:0] r_partial, n_partial;
    logic [15:0]              r_text_pos, n_text_pos;
    t_status                  r_final, n_final;
    logic [15:0]              r_found_pos, n_found_pos;

    logic [PW-1:0]            len;
    logic [PATTERN_DEPTH-1:0] len_mask;
    logic [PATTERN_DEPTH-1:0] last_sel;
    logic [PATTERN_DEPTH-1:0] pm_next;
    logic                     matched;
    logic [15:0]              pos_inc;
    logic [15:0]              match_start;

    // effective pattern length: shorter of first nul and pattern limit
    assign len = (16'(i_nul_index) > i_pattern_limit) ? i_pattern_limit[PW-1:0]
                                                      : i_nul_index;

    always_comb begin
        for (int i = 0; i < PATTERN_DEPTH; i++) begin
            len_mask[i] = (int'(len) > i);
            last_sel[i] = (int'(len) == i + 1);
        end
    end

    assign pm_next     = ((r_partial << 1) | PATTERN_DEPTH'(1)) & i_hits & len_mask;
    assign matched     = |(pm_next & last_sel);
    assign pos_inc     = r_text_pos + 16'd1;
    assign match_start = pos_inc - 16'(len);

    always_comb begin
        n_partial   = r_partial;
        n_text_pos  = r_text_pos;
        n_final     = r_final;
        n_found_pos = r_found_pos;
        if (i_step) begin
            case (i_op)
                OP_TEXT: begin
                    if (r_final == ST_SEARCHING) begin
                        if (i_text_limit == '0) begin
                            n_final = ST_TEXT_LIM_ZERO;
                        end else if (i_text_limit > MaxLen) begin
                            n_final = ST_TEXT_LIM_BIG;
                        end else if (i_nul_index == '0) begin
                            // empty pattern matches at the start
                            n_final     = ST_FOUND;
                            n_found_pos = '0;
                        end else if (i_pattern_limit == '0) begin
                            n_final = ST_PAT_LIM_ZERO;
                        end else if (i_pattern_limit > MaxLen) begin
                            n_final = ST_PAT_LIM_BIG;
                        end else if (16'(i_nul_index) == Depth && i_pattern_limit > Depth) begin
                            n_final = ST_PAT_OVER_STORE;
                        end else if (i_char == '0) begin
                            n_final = ST_NOT_FOUND;
                        end else begin
                            n_partial = pm_next;
                            if (matched) begin
                                n_final     = ST_FOUND;
                                n_found_pos = match_start;
                            end else begin
                                n_text_pos = pos_inc;
                                if (pos_inc >= i_text_limit) begin
                                    n_final = ST_NOT_FOUND;
                                end
                            end
                        end
                    end
                end
                OP_RESTART: begin
                    n_partial   = '0;
                    n_text_pos  = '0;
                    n_final     = ST_SEARCHING;
                    n_found_pos = '0;
                end
                default: begin
                    n_partial = r_partial;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_text_pos  <= '0;
            r_final     <= ST_SEARCHING;
            r_found_pos <= '0;
        end else begin
            r_partial   <= n_partial;
            r_text_pos  <= n_text_pos;
            r_final     <= n_final;
            r_found_pos <= n_found_pos;
        end
    end

    assign o_result.status         = n_final;
    assign o_result.match_position = (n_final == ST_FOUND) ? n_found_pos : '0;

    // a closed search ignores further text
    a_closed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_op == OP_TEXT && r_final != ST_SEARCHING
        |=> $stable(r_text_pos) && $stable(r_partial) && $stable(r_final))
        else $error("closed search changed state on text");

endmodule

// ===== hdl/bounded_wide_substring_search.sv =====
// ---------------------------------------------------------------------------
// bounded_wide_substring_search
// first-occurrence search of a stored wide-character pattern in streamed text
// ---------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item): one transaction per
//   op: write a pattern character, feed a text character, restart, or no-op
//   output channel (o_out_valid / i_out_ready / o_out_item): exactly one
//   result per input transaction, in order, with status and match start
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 text limit, index 1 pattern limit, others dropped; always ready,
//   write only while the block is idle
//   result path: an accepted input transaction is held in the input
//   register, then compare and shift-and run on it and write the result
//   register, which offers it on the output channel
//   throughput: one transaction per cycle while the receiver takes results;
//   the shift-and update and all store comparators are combinational
//   reset: pattern store cleared to nul, search open, limits 1024 and 32
//   receiver stall: the result register holds, the input register takes one
//   more transaction, then o_in_ready drops until the result is taken
// ---------------------------------------------------------------------------
module bounded_wide_substring_search #(
    parameter int PATTERN_DEPTH = 32,
    parameter int MAX_LENGTH    = 1024,
    parameter int CHAR_WIDTH    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bwss_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bwss_pkg::t_result  o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import bwss_pkg::*;

    localparam int PW = $clog2(PATTERN_DEPTH + 1);

    // configuration registers
    logic [15:0] r_text_limit;
    logic [15:0] r_pattern_limit;

    // input register stage
    logic     r_in_valid, n_in_valid;
    t_in_item r_in;

    // result register stage
    logic     r_out_valid, n_out_valid;
    t_result  r_out;

    logic                     in_accept;
    logic                     advance;
    logic [CHAR_WIDTH-1:0]    stage_char;
    logic [PW-1:0]            nul_index;
    logic [PATTERN_DEPTH-1:0] hits;
    t_result                  step_result;

    // stage moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // only the low character-width bits of a character count
    assign stage_char = r_in.char_value[CHAR_WIDTH-1:0];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_limit    <= TEXT_LIMIT_RST;
            r_pattern_limit <= PATTERN_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEXT_LIMIT:    r_text_limit    <= i_cfg_data;
                CFG_PATTERN_LIMIT: r_pattern_limit <= i_cfg_data;
                default: begin
                    r_text_limit <= r_text_limit;
                end
            endcase
        end
    end

    // input stage
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    bwss_store #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .CHAR_WIDTH    (CHAR_WIDTH),
        .PW            (PW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (advance && r_in.op == OP_WRITE_PATTERN),
        .i_wr_index  (r_in.pattern_index),
        .i_char      (stage_char),
        .o_nul_index (nul_index),
        .o_hits      (hits)
    );

    bwss_search #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .MAX_LENGTH    (MAX_LENGTH),
        .CHAR_WIDTH    (CHAR_WIDTH),
        .PW            (PW)
    ) u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_op            (r_in.op),
        .i_char          (stage_char),
        .i_nul_index     (nul_index),
        .i_hits          (hits),
        .i_text_limit    (r_text_limit),
        .i_pattern_limit (r_pattern_limit),
        .o_result        (step_result)
    );

    // result stage
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a staged transaction waiting on a full result register is kept intact
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("staged transaction lost while stalled");

    // a match position is reported only with a found status
    a_pos_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_FOUND |-> r_out.match_position == '0)
        else $error("match position without found status");

    // restart reports an open search at position zero
    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.op == OP_RESTART
        |=> r_out_valid && r_out.status == ST_SEARCHING && r_out.match_position == '0)
        else $error("restart did not reopen the search");

endmodule
